// ===== sv/qhse_pkg.sv =====
// shared types, constants and helpers of the quintic hermite segment evaluator
`timescale 1ns / 1ps

package qhse_pkg;

   localparam int T_FRAC_BITS = 16;
   localparam int T_W         = T_FRAC_BITS + 1;
   localparam int POS_W       = 32;
   localparam int COEF_W      = 40;
   localparam int ACC_W       = 43;
   localparam int PROD_W      = ACC_W + T_W + 1;
   localparam int NUM_AXES    = 3;
   localparam int AXIS_W      = 2;
   localparam int NUM_COEF    = 6;
   localparam int NUM_STEPS   = NUM_COEF - 1;
   localparam int NUM_STAGES  = NUM_STEPS + 1;
   localparam int CQ_DEPTH    = NUM_STEPS * (NUM_STEPS + 1) / 2;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_EVAL = 1'b1
   } kind_type;

   typedef logic signed [POS_W-1:0]  pos_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic        [T_W-1:0]    t_type;

   localparam t_type T_ONE = t_type'(1) << T_FRAC_BITS;

   // per-stage capture strobes of the evaluation pipeline
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic                  out_load;
   } pipe_ctrl_type;

   // start of the coefficient queue that stage s carries (entries shrink by one per stage)
   function automatic int cq_base(input int s);
      return s * NUM_STEPS - (s * (s - 1)) / 2;
   endfunction

   function automatic coef_type ext_coef(input pos_type v);
      return coef_type'(v);
   endfunction

endpackage

// ===== sv/quintic_hermite_segment_eval.sv =====
// Quintic Hermite segment evaluator for three axes, signed Q16.16 positions.
//
// Request channel (req_valid / req_stall): a beat with req_kind load writes the
// six coefficients of one axis from the start/end position, velocity and
// acceleration and gives no response; axis code three is dropped. A beat with
// req_kind eval samples all three axes at req_t_frac (Q1.16, clamped to one).
// Response channel (rsp_valid / rsp_stall): one beat per eval with the three
// positions, floored and saturated to 32 bits.
// Path: an eval beat passes the snapshot register, loaded at the accept edge,
// then five horner stages, then one output register, whose load raises
// rsp_valid.
// Throughput: one beat per cycle while req_stall is low, loads and evals mixed
// freely; a load is seen by every eval accepted after it. The rate is set by
// the lane pipeline, one multiply-add per stage per axis.
// Stall: while rsp_stall holds a response, bubbles in the pipeline close up and
// beats keep being accepted until every stage is full, then req_stall rises.
// Reset: coefficients clear to zero (unloaded axes evaluate to 0) and the
// pipeline empties.
`timescale 1ns / 1ps

module quintic_hermite_segment_eval
   import qhse_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [AXIS_W-1:0]   req_axis,
   input  pos_type             req_start_pos,
   input  pos_type             req_end_pos,
   input  pos_type             req_start_vel,
   input  pos_type             req_end_vel,
   input  pos_type             req_start_acc,
   input  pos_type             req_end_acc,
   input  t_type               req_t_frac,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pos_type             rsp_pos_x,
   output pos_type             rsp_pos_y,
   output pos_type             rsp_pos_z
);

   logic [NUM_STAGES-1:0] v_ff, v_in, pass;
   logic [NUM_STAGES:0]   room;
   logic                  accept;
   t_type                 t_clamped;
   pipe_ctrl_type         ctrl;
   coef_type              coefs [NUM_AXES][NUM_COEF];
   acc_type               lane_acc [NUM_AXES];
   pos_type               pos [NUM_AXES];

   always_comb begin
      room[NUM_STAGES] = !rsp_valid || !rsp_stall;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         pass[i] = v_ff[i] && room[i+1];
         room[i] = !v_ff[i] || room[i+1];
      end
      req_stall = !room[0];
      accept    = req_valid && !req_stall;
      ctrl.load[0] = accept && (req_kind == KIND_EVAL);
      for (int i = 1; i < NUM_STAGES; i++) begin
         ctrl.load[i] = pass[i-1];
      end
      ctrl.out_load = pass[NUM_STAGES-1];
      for (int i = 0; i < NUM_STAGES; i++) begin
         v_in[i] = ctrl.load[i] || (v_ff[i] && !pass[i]);
      end
      t_clamped = (req_t_frac > T_ONE) ? T_ONE : req_t_frac;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   qhse_coef_store u_store (
      .clock     (clock),
      .reset     (reset),
      .load_en   (accept && (req_kind == KIND_LOAD)),
      .axis      (req_axis),
      .start_pos (req_start_pos),
      .end_pos   (req_end_pos),
      .start_vel (req_start_vel),
      .end_vel   (req_end_vel),
      .start_acc (req_start_acc),
      .end_acc   (req_end_acc),
      .coefs     (coefs)
   );

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      qhse_lane u_lane (
         .clock   (clock),
         .ctrl    (ctrl),
         .t_in    (t_clamped),
         .coefs   (coefs[a]),
         .acc_out (lane_acc[a])
      );
   end

   qhse_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .acc_in    (lane_acc),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .pos       (pos)
   );

   assign rsp_pos_x = pos[0];
   assign rsp_pos_y = pos[1];
   assign rsp_pos_z = pos[2];

endmodule

// ===== sv/qhse_coef_store.sv =====
// coefficient former and per-axis coefficient registers
`timescale 1ns / 1ps

module qhse_coef_store
   import qhse_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load_en,
   input  logic [AXIS_W-1:0]   axis,
   input  pos_type             start_pos,
   input  pos_type             end_pos,
   input  pos_type             start_vel,
   input  pos_type             end_vel,
   input  pos_type             start_acc,
   input  pos_type             end_acc,
   output coef_type            coefs [NUM_AXES][NUM_COEF]
);

   coef_type coef_ff [NUM_AXES][NUM_COEF];
   coef_type new_coef [NUM_COEF];
   coef_type p0e, v0e, v1e, a0e, a1e, dp;

   // every value is doubled, so all coefficients are whole numbers
   always_comb begin
      p0e = ext_coef(start_pos);
      v0e = ext_coef(start_vel);
      v1e = ext_coef(end_vel);
      a0e = ext_coef(start_acc);
      a1e = ext_coef(end_acc);
      dp  = ext_coef(end_pos) - p0e;
      new_coef[0] = p0e <<< 1;
      new_coef[1] = v0e <<< 1;
      new_coef[2] = a0e;
      new_coef[3] = (dp <<< 4) + (dp <<< 2) - (v0e <<< 3) - (v0e <<< 2) - (v1e <<< 3)
                  - (a0e <<< 1) - a0e + a1e;
      new_coef[4] = (dp <<< 1) - (dp <<< 5) + (v0e <<< 4) + (v1e <<< 4) - (v1e <<< 1)
                  + (a0e <<< 1) + a0e - (a1e <<< 1);
      new_coef[5] = (dp <<< 3) + (dp <<< 2) - (v0e <<< 2) - (v0e <<< 1) - (v1e <<< 2)
                  - (v1e <<< 1) - a0e + a1e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            for (int k = 0; k < NUM_COEF; k++) begin
               coef_ff[a][k] <= '0;
            end
         end
      end else if (load_en) begin
         // axis code three matches no row and is dropped
         for (int a = 0; a < NUM_AXES; a++) begin
            if (axis == AXIS_W'(a)) begin
               for (int k = 0; k < NUM_COEF; k++) begin
                  coef_ff[a][k] <= new_coef[k];
               end
            end
         end
      end
   end

   assign coefs = coef_ff;

endmodule

// ===== sv/qhse_lane.sv =====
// one axis lane: pipelined horner evaluation, one multiply-add per stage
`timescale 1ns / 1ps

module qhse_lane
   import qhse_pkg::*;
(
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  t_type         t_in,
   input  coef_type      coefs [NUM_COEF],
   output acc_type       acc_out
);

   acc_type  acc_ff [NUM_STAGES];
   t_type    t_ff   [NUM_STEPS];
   coef_type cq_ff  [CQ_DEPTH];

   logic signed [PROD_W-1:0] prod     [NUM_STEPS];
   acc_type                  step_acc [NUM_STEPS];

   always_comb begin
      for (int s = 0; s < NUM_STEPS; s++) begin
         prod[s]     = acc_ff[s] * $signed({1'b0, t_ff[s]});
         step_acc[s] = acc_type'(prod[s] >>> T_FRAC_BITS) + acc_type'(cq_ff[cq_base(s)]);
      end
   end

   always_ff @(posedge clock) begin
      // snapshot the whole axis at accept so later loads do not leak in
      if (ctrl.load[0]) begin
         acc_ff[0] <= acc_type'(coefs[NUM_COEF-1]);
         t_ff[0]   <= t_in;
         for (int j = 0; j < NUM_STEPS; j++) begin
            cq_ff[cq_base(0) + j] <= coefs[NUM_STEPS-1-j];
         end
      end
      for (int s = 0; s < NUM_STEPS; s++) begin
         if (ctrl.load[s+1]) begin
            acc_ff[s+1] <= step_acc[s];
         end
      end
      for (int s = 0; s < NUM_STEPS - 1; s++) begin
         if (ctrl.load[s+1]) begin
            t_ff[s+1] <= t_ff[s];
            for (int j = 0; j < NUM_STEPS - 1 - s; j++) begin
               cq_ff[cq_base(s+1) + j] <= cq_ff[cq_base(s) + j + 1];
            end
         end
      end
   end

   assign acc_out = acc_ff[NUM_STEPS];

endmodule

// ===== sv/qhse_merge.sv =====
// merging stage: halves and saturates the lane results into the output register
`timescale 1ns / 1ps

module qhse_merge
   import qhse_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  pipe_ctrl_type ctrl,
   input  acc_type       acc_in [NUM_AXES],
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output pos_type       pos [NUM_AXES]
);

   localparam logic signed [ACC_W-2:0] POS_MAX = (ACC_W-1)'({1'b0, {(POS_W-1){1'b1}}});
   localparam logic signed [ACC_W-2:0] POS_MIN = (ACC_W-1)'($signed({1'b1, {(POS_W-1){1'b0}}}));

   logic    valid_ff, valid_in;
   pos_type pos_ff [NUM_AXES];
   pos_type pos_in [NUM_AXES];
   logic signed [ACC_W-2:0] half [NUM_AXES];

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         half[a] = (ACC_W-1)'(acc_in[a] >>> 1);
         if (half[a] > POS_MAX) begin
            pos_in[a] = POS_MAX[POS_W-1:0];
         end else if (half[a] < POS_MIN) begin
            pos_in[a] = POS_MIN[POS_W-1:0];
         end else begin
            pos_in[a] = half[a][POS_W-1:0];
         end
      end
      valid_in = ctrl.out_load || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         pos_ff <= pos_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign pos       = pos_ff;

endmodule

// ===== sv/qhse_checker.sv =====
// port-level checker for the segment evaluator and its bind
`timescale 1ns / 1ps

module qhse_checker
   import qhse_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_kind,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input pos_type             rsp_pos_x,
   input pos_type             rsp_pos_y,
   input pos_type             rsp_pos_z
);

   logic eval_beat;
   assign eval_beat = req_valid && !req_stall && (req_kind == KIND_EVAL);

   // a held response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_x)
         && $stable(rsp_pos_y) && $stable(rsp_pos_z))
      else $error("response beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // with the output register empty the whole pipeline has room
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // an eval beat with an unstalled receiver reaches the response port once it has passed the pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $past(eval_beat, 7) && !$past(rsp_stall, 1) && !$past(rsp_stall, 2)
         && !$past(rsp_stall, 3) && !$past(rsp_stall, 4) && !$past(rsp_stall, 5)
         && !$past(rsp_stall, 6) && !$past(reset, 1) && !$past(reset, 2)
         && !$past(reset, 3) && !$past(reset, 4) && !$past(reset, 5)
         && !$past(reset, 6) && !$past(reset, 7)
      |-> rsp_valid)
      else $error("eval beat response missing after pipeline latency");

endmodule

bind quintic_hermite_segment_eval qhse_checker u_qhse_checker (.*);
